// ===== hdl/cfilt_pkg.sv =====
// Package for the 3x3 image filter: sizes, config register indexes and the
// pipeline record handed from cell to cell. No dependencies.
package cfilt_pkg;

  localparam int unsigned MaxWidthDef   = 1024;
  localparam int unsigned KernelSizeDef = 3;
  localparam int unsigned CoeffFracDef  = 8;
  localparam int unsigned MaxHeight     = 4096;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 12;
  localparam int unsigned KrowW  = 36;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HgtW   = 13;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned Taps   = 9;
  // running sum, wide enough for nine taps at the smallest fraction width
  localparam int unsigned SumW   = 24;

  typedef enum logic [IdxW-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_KTOP    = 3'd2,
    REG_KMIDDLE = 3'd3,
    REG_KBOTTOM = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                        valid;
    logic                        inner;
    logic                        last;
    logic [PixW-1:0]             centre;
    logic [Taps-1:0][PixW-1:0]   win;
    logic signed [SumW-1:0]      sum;
  } cell_t;

endpackage

// ===== hdl/cfilt_if.sv =====
// Stream and config channel interfaces of the 3x3 image filter.
// Depends on cfilt_pkg.
interface cfilt_in_if import cfilt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            drain;
  modport source (output valid, pixel_in, drain, input ready);
  modport sink   (input valid, pixel_in, drain, output ready);
endinterface

interface cfilt_out_if import cfilt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            last_of_frame;
  modport source (output valid, pixel_out, last_of_frame, input ready);
  modport sink   (input valid, pixel_out, last_of_frame, output ready);
endinterface

interface cfilt_cfg_if import cfilt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [KrowW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cfilt_linebuf.sv =====
// Two-row line store (upper and lower row packed per column), one write and
// one registered read per cycle with write-to-read forwarding. Uses cfilt_pkg.
module cfilt_linebuf import cfilt_pkg::*; #(
  parameter int unsigned Depth = MaxWidthDef
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [2*PixW-1:0]          wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [2*PixW-1:0]          rdata_o
);

  logic [2*PixW-1:0] mem [Depth];
  logic [2*PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cfilt_cell.sv =====
// One tap of the filter chain: multiply-accumulate with truncation toward
// zero, then hand the record to the next cell. Uses cfilt_pkg.
module cfilt_cell import cfilt_pkg::*; #(
  parameter int unsigned Tap      = 0,
  parameter int unsigned CoefFrac = CoeffFracDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [CoefW-1:0] coeff_i,
  input  cell_t            stage_i,
  output cell_t            stage_o
);

  localparam int unsigned TW = SumW + CoefFrac + 1;

  logic signed [PixW+CoefW:0] prod;
  logic signed [TW-1:0]       t;
  logic signed [TW-1:0]       tq;
  cell_t                      nxt;
  cell_t                      stage_q;
  logic                       valid_q;

  always_comb begin
    prod = $signed({1'b0, stage_i.win[Tap]}) * $signed(coeff_i);
    t    = (TW'(stage_i.sum) <<< CoefFrac) + TW'(prod);
    if (t < 0) begin
      tq = (t + TW'((1 << CoefFrac) - 1)) >>> CoefFrac;
    end else begin
      tq = t >>> CoefFrac;
    end
    nxt     = stage_i;
    nxt.sum = tq[SumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= nxt;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

// ===== hdl/conv3x3_image_filter.sv =====
// Top level of the 3x3 image filter: frame counters, window, line store,
// nine-cell tap chain and output register. Uses cfilt_pkg, cfilt_if.
//
//   channel | dir | payload                       | handshake
//   in_i    | in  | pixel_in[7:0], drain          | valid/ready
//   out_o   | out | pixel_out[7:0], last_of_frame | valid/ready
//   cfg_i   | in  | index[2:0], data[35:0]        | valid/ready
//
// One pixel per clock while the input is not stalled. A result passes through
// the nine tap cells and the output register. The chain and the input stall
// together only while the output register holds a result not taken. A width
// write holds the input and config off while the output position is recomputed.
// Reset clears counters, valids and the window; the line store is not reset.
module conv3x3_image_filter import cfilt_pkg::*; #(
  parameter int unsigned MaxWidth   = MaxWidthDef,
  parameter int unsigned KernelSize = KernelSizeDef,
  parameter int unsigned CoeffFrac  = CoeffFracDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfilt_in_if.sink     in_i,
  cfilt_out_if.source  out_o,
  cfilt_cfg_if.sink    cfg_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned Ctr  = KernelSize / 2;
  // output count covers the largest frame; rebase counter steps over its bits
  localparam int unsigned CntW = WidthW + HgtW - 1;
  localparam int unsigned RbW  = $clog2(CntW);

  logic [WidthW-1:0] width_q;
  logic [HgtW-1:0]   height_q;
  logic [KrowW-1:0]  ktop_q, kmid_q, kbot_q;
  logic              rb_busy_q, rb_busy_d;
  logic              wr_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(1024);
      height_q <= HgtW'(1024);
      ktop_q   <= '0;
      kmid_q   <= KrowW'(1048576);
      kbot_q   <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_WIDTH:   width_q  <= cfg_i.data[WidthW-1:0];
        REG_HEIGHT:  height_q <= cfg_i.data[HgtW-1:0];
        REG_KTOP:    ktop_q   <= cfg_i.data;
        REG_KMIDDLE: kmid_q   <= cfg_i.data;
        REG_KBOTTOM: kbot_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end
  assign cfg_i.ready = !rb_busy_q;
  assign wr_width    = cfg_i.valid && cfg_i.ready && (cfg_i.index == REG_WIDTH);

  // effective sizes
  logic [WidthW-1:0] w;
  logic [HgtW-1:0]   h;
  always_comb begin
    if (width_q == '0) w = WidthW'(1);
    else if (32'(width_q) > MaxWidth) w = WidthW'(MaxWidth);
    else w = width_q;
    if (height_q == '0) h = HgtW'(1);
    else if (32'(height_q) > MaxHeight) h = HgtW'(MaxHeight);
    else h = height_q;
  end

  logic [ColW-1:0]   in_col_q, in_col_d;
  logic [HgtW-1:0]   in_row_q, in_row_d;
  logic [WidthW-1:0] out_col_q, out_col_d;
  logic [HgtW-1:0]   out_row_q, out_row_d;
  logic [CntW-1:0]   out_cnt_q, out_cnt_d;
  logic              done_q, done_d;
  logic [Taps-1:0][PixW-1:0] win_q, win_d;
  logic [RbW-1:0]    rb_cnt_q, rb_cnt_d;
  logic [CntW-1:0]   rb_quo_q, rb_quo_d;
  logic [WidthW-1:0] rb_rem_q, rb_rem_d;
  logic [WidthW:0]   rb_sh;
  logic [CntW:0]     total;

  logic              en, accept, done_eff, shift, emit, last, inner;
  logic [PixW-1:0]   pix;
  logic [2*PixW-1:0] lb_rd;
  logic [ColW:0]     col_inc;
  cell_t             chain [Taps+1];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en && !rb_busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign done_eff   = done_q || (in_row_q >= h);
  assign col_inc    = {1'b0, in_col_q} + 1'b1;
  assign total      = (CntW+1)'(w) * (CntW+1)'(h);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_cnt_d = out_cnt_q;
    done_d    = done_q;
    win_d     = win_q;
    rb_busy_d = rb_busy_q;
    rb_cnt_d  = rb_cnt_q;
    rb_quo_d  = rb_quo_q;
    rb_rem_d  = rb_rem_q;
    rb_sh     = {rb_rem_q, rb_quo_q[CntW-1]};
    shift     = 1'b0;
    emit      = 1'b0;
    pix       = in_i.pixel_in;
    if (accept) begin
      if (!done_eff) begin
        if (!in_i.drain) begin
          shift = 1'b1;
          emit  = (in_row_q >= HgtW'(2)) ||
                  (in_row_q == HgtW'(1) && in_col_q != '0);
          if (32'(col_inc) >= 32'(w)) begin
            in_col_d = '0;
            in_row_d = in_row_q + 1'b1;
            if (in_row_q + 1'b1 >= h) done_d = 1'b1;
          end else begin
            in_col_d = col_inc[ColW-1:0];
          end
        end
      end else begin
        shift = 1'b1;
        emit  = 1'b1;
        pix   = '0;
        done_d = 1'b1;
        if (32'(col_inc) >= 32'(w)) in_col_d = '0;
        else in_col_d = col_inc[ColW-1:0];
      end
    end
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]   = win_q[r*3+1];
        win_d[r*3+1] = win_q[r*3+2];
      end
      win_d[2] = lb_rd[2*PixW-1:PixW];
      win_d[5] = lb_rd[PixW-1:0];
      win_d[8] = pix;
    end
    last  = ({1'b0, out_cnt_q} + 1'b1) >= total;
    inner = (w >= WidthW'(3)) && (h >= HgtW'(3)) && (out_row_q >= HgtW'(1)) &&
            (out_row_q + 1'b1 < h) && (out_col_q >= WidthW'(1)) &&
            (out_col_q + 1'b1 < w);
    if (emit) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        out_cnt_d = '0;
        done_d    = 1'b0;
      end else begin
        out_cnt_d = out_cnt_q + 1'b1;
        if (out_col_q + 1'b1 >= w) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
    // new width: row and column of the output count, one quotient bit a cycle
    if (wr_width) begin
      rb_busy_d = 1'b1;
      rb_cnt_d  = '0;
      rb_quo_d  = out_cnt_d;
      rb_rem_d  = '0;
    end else if (rb_busy_q) begin
      if (rb_sh >= {1'b0, w}) begin
        rb_rem_d = WidthW'(rb_sh - {1'b0, w});
        rb_quo_d = {rb_quo_q[CntW-2:0], 1'b1};
      end else begin
        rb_rem_d = rb_sh[WidthW-1:0];
        rb_quo_d = {rb_quo_q[CntW-2:0], 1'b0};
      end
      rb_cnt_d = rb_cnt_q + 1'b1;
      if (rb_cnt_q == RbW'(CntW - 1)) begin
        rb_busy_d = 1'b0;
        out_col_d = rb_rem_d;
        // a row past any height only needs to stay past it
        out_row_d = (rb_quo_d[CntW-1:HgtW] != '0) ? '1 : rb_quo_d[HgtW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_cnt_q <= '0;
      done_q    <= 1'b0;
      win_q     <= '0;
      rb_busy_q <= 1'b0;
      rb_cnt_q  <= '0;
      rb_quo_q  <= '0;
      rb_rem_q  <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      out_cnt_q <= out_cnt_d;
      done_q    <= done_d;
      win_q     <= win_d;
      rb_busy_q <= rb_busy_d;
      rb_cnt_q  <= rb_cnt_d;
      rb_quo_q  <= rb_quo_d;
      rb_rem_q  <= rb_rem_d;
    end
  end

  // read port tracks the column of the next item
  cfilt_linebuf #(.Depth(MaxWidth)) u_linebuf (
    .clk_i   (clk_i),
    .we_i    (shift),
    .waddr_i (in_col_q),
    .wdata_i ({lb_rd[PixW-1:0], pix}),
    .raddr_i (in_col_d),
    .rdata_o (lb_rd)
  );

  always_comb begin
    chain[0].valid  = emit;
    chain[0].inner  = inner;
    chain[0].last   = last;
    chain[0].centre = win_d[Ctr*3+Ctr];
    chain[0].win    = win_d;
    chain[0].sum    = '0;
  end

  for (genvar k = 0; k < Taps; k++) begin : g_tap
    logic [KrowW-1:0] krow;
    assign krow = (k < 3) ? ktop_q : ((k < 6) ? kmid_q : kbot_q);
    cfilt_cell #(.Tap(k), .CoefFrac(CoeffFrac)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .coeff_i (krow[(k%3)*CoefW +: CoefW]),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[Taps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q  <= chain[Taps].inner ? chain[Taps].sum[PixW-1:0] : chain[Taps].centre;
      out_last_q <= chain[Taps].last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_out     = out_pix_q;
  assign out_o.last_of_frame = out_last_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for conv3x3_image_filter: drives pixel and drain
// transfers, predicts each filtered pixel and compares field by field.
// Depends on cfilt_pkg, cfilt_if and the filter RTL.
module testbench;
  import cfilt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 12;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            drain;
  } pix_item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } pix_res_t;

  typedef struct {
    bit       is_cfg;
    reg_idx_e idx;
    logic [KrowW-1:0] data;
    pix_item_t item;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfilt_in_if  in_ch ();
  cfilt_out_if out_ch ();
  cfilt_cfg_if cfg_ch ();

  conv3x3_image_filter uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // predictor state
  logic [PixW-1:0] upper_row [MaxWidthDef];
  logic [PixW-1:0] lower_row [MaxWidthDef];
  logic [PixW-1:0] win [3][3];
  int unsigned col_cnt, row_cnt, emit_cnt;
  bit          frame_in;
  logic [WidthW-1:0] width_reg;
  logic [HgtW-1:0]   height_reg;
  logic [KrowW-1:0]  krow [3];

  step_t     pending_q [$];
  pix_res_t  expected_q [$];
  int unsigned errors = 0, cycle_cnt = 0, accepted = 0, results = 0;
  int        idle_pct, stall_pct;
  bit        hold_off;

  always #4 clk_i = ~clk_i;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0d: %s", cycle_cnt, what);
  endtask

  function automatic int unsigned eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < 1) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  function automatic void shift_window(input logic [PixW-1:0] pix);
    int unsigned c;
    c = (col_cnt >= MaxWidthDef) ? MaxWidthDef - 1 : col_cnt;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_row[c];
    win[1][2] = lower_row[c];
    win[2][2] = pix;
    upper_row[c] = lower_row[c];
    lower_row[c] = pix;
  endfunction

  function automatic logic [PixW-1:0] convolve();
    longint s, t, k;
    logic [CoefW-1:0] raw;
    s = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        raw = krow[r][12*c +: 12];
        k = longint'($signed(raw));
        t = s * 256 + longint'(win[r][c]) * k;
        s = t / 256;  // truncates toward zero
      end
    return s[7:0];
  endfunction

  function automatic void emit_result(input int unsigned w, input int unsigned h);
    pix_res_t    res;
    int unsigned r, c;
    bit          inner;
    r = emit_cnt / w;
    c = emit_cnt % w;
    res.last = (emit_cnt + 1 >= w * h);
    inner = w >= 3 && h >= 3 && r >= 1 && r + 1 < h && c >= 1 && c + 1 < w;
    res.pixel = inner ? convolve() : win[1][1];
    expected_q.push_back(res);
    if (res.last) begin
      col_cnt = 0; row_cnt = 0; emit_cnt = 0; frame_in = 0;
    end else
      emit_cnt++;
  endfunction

  function automatic void predict(input pix_item_t it);
    int unsigned w, h;
    bit emit;
    w = eff_w();
    h = eff_h();
    if (!frame_in && row_cnt >= h) frame_in = 1;
    if (!frame_in) begin
      if (it.drain) return;
      emit = row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
      shift_window(it.pixel);
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) frame_in = 1;
      end
      if (emit) emit_result(w, h);
      return;
    end
    shift_window('0);
    col_cnt++;
    if (col_cnt >= w) col_cnt = 0;
    emit_result(w, h);
  endfunction

  function automatic void apply_cfg(input reg_idx_e idx, input logic [KrowW-1:0] d);
    case (idx)
      REG_WIDTH:   width_reg  = d[WidthW-1:0];
      REG_HEIGHT:  height_reg = d[HgtW-1:0];
      REG_KTOP:    krow[0] = d;
      REG_KMIDDLE: krow[1] = d;
      REG_KBOTTOM: krow[2] = d;
      default: ;
    endcase
  endfunction

  function automatic void add_cfg(input reg_idx_e idx, input logic [KrowW-1:0] d);
    step_t s;
    s.is_cfg = 1; s.idx = idx; s.data = d; s.item = '0;
    pending_q.push_back(s);
  endfunction

  function automatic void add_pix(input logic [PixW-1:0] p, input bit dr);
    step_t s;
    s.is_cfg = 0; s.idx = REG_WIDTH; s.data = '0;
    s.item.pixel = p; s.item.drain = dr;
    pending_q.push_back(s);
  endfunction

  function automatic logic [KrowW-1:0] rand_krow();
    return {4'($urandom_range(0, 15)), $urandom()};
  endfunction

  // one whole frame: pixels, random drain noise, then enough drains to flush
  function automatic void add_frame(input int unsigned w, input int unsigned h,
                                    input int noise_pct, input bit extreme);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) add_pix(8'($urandom()), 1'b1);
      if (extreme) add_pix((i % 2) ? 8'hff : 8'h00, 1'b0);
      else add_pix(8'($urandom()), 1'b0);
    end
    // a pixel after the frame acts as a drain
    for (int unsigned i = 0; i < w + 1; i++)
      add_pix(8'($urandom()), 1'($urandom_range(1)));
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.pixel_in <= '0;
      in_ch.drain <= 1'b0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= '0;
      cfg_ch.data <= '0;
      width_reg = WidthW'(1024); height_reg = HgtW'(1024);
      krow[0] = '0; krow[1] = 36'h000100000; krow[2] = '0;
      foreach (win[r, c]) win[r][c] = '0;
      col_cnt = 0; row_cnt = 0; emit_cnt = 0; frame_in = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict('{pixel: in_ch.pixel_in, drain: in_ch.drain});
        accepted++;
      end
      if (cfg_ch.valid && cfg_ch.ready) apply_cfg(reg_idx_e'(cfg_ch.index), cfg_ch.data);
      if ((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
        // hold current transfer
      end else if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
        in_ch.valid <= 1'b0;
        if (!cfg_ch.valid && expected_q.size() == 0 && !in_ch.valid) begin
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= pending_q[0].idx;
          cfg_ch.data  <= pending_q[0].data;
          void'(pending_q.pop_front());
        end else
          cfg_ch.valid <= 1'b0;
      end else begin
        cfg_ch.valid <= 1'b0;
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.pixel_in <= pending_q[0].item.pixel;
          in_ch.drain <= pending_q[0].item.drain;
          void'(pending_q.pop_front());
        end else
          in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results++;
        if (expected_q.size() == 0)
          report($sformatf("unexpected result %02h", out_ch.pixel_out));
        else begin
          if (out_ch.pixel_out !== expected_q[0].pixel)
            report($sformatf("pixel_out %02h, want %02h", out_ch.pixel_out,
                             expected_q[0].pixel));
          if (out_ch.last_of_frame !== expected_q[0].last)
            report($sformatf("last_of_frame %b, want %b", out_ch.last_of_frame,
                             expected_q[0].last));
          void'(expected_q.pop_front());
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("FAIL conv3x3_image_filter");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    int unsigned n;
    hold_off = 0;
    wait (accepted > 200);
    hold_off = 1;
    n = 0;
    while (n < 300) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 0;
  end

  task automatic run_phase(input int ip, input int sp);
    idle_pct = ip;
    stall_pct = sp;
    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (expected_q.size() == 0);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w, h;
    idle_pct = 0; stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: drain mid-frame, tiny frames, extreme kernels and pixels
    add_cfg(REG_WIDTH, 4); add_cfg(REG_HEIGHT, 3);
    add_cfg(REG_KTOP, 36'h7ff_800_7ff);
    add_cfg(REG_KMIDDLE, 36'h800_7ff_800);
    add_cfg(REG_KBOTTOM, 36'hfff_001_fff);
    add_pix(8'h00, 1);
    add_frame(4, 3, 0, 1);
    add_cfg(REG_WIDTH, 1); add_cfg(REG_HEIGHT, 1);
    add_frame(1, 1, 0, 1);
    add_cfg(REG_WIDTH, 0); add_cfg(REG_HEIGHT, 0);
    add_frame(1, 1, 0, 0);
    add_cfg(REG_WIDTH, 2); add_cfg(REG_HEIGHT, 2);
    add_frame(2, 2, 30, 0);
    run_phase(0, 0);

    // random frames in four idling phases, small sizes mostly
    for (int ph = 0; ph < 4; ph++) begin
      for (int f = 0; f < 5; f++) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        add_cfg(REG_WIDTH, w); add_cfg(REG_HEIGHT, h);
        add_cfg(REG_KTOP, rand_krow());
        add_cfg(REG_KMIDDLE, rand_krow());
        add_cfg(REG_KBOTTOM, rand_krow());
        add_frame(w, h, 10, 0);
      end
      case (ph)
        0: run_phase(0, 0);
        1: run_phase(58, 0);
        2: run_phase(0, 58);
        default: run_phase(28, 28);
      endcase
    end

    // one wide frame, then out-of-range size settings
    add_cfg(REG_WIDTH, 128); add_cfg(REG_HEIGHT, 3);
    add_cfg(REG_KTOP, rand_krow());
    add_frame(128, 3, 0, 0);
    run_phase(10, 10);
    add_cfg(REG_WIDTH, 2047); add_cfg(REG_HEIGHT, 8191);
    run_phase(0, 0);
    add_cfg(REG_WIDTH, 3); add_cfg(REG_HEIGHT, 3);
    add_frame(3, 3, 0, 1);
    run_phase(0, 0);

    $display("covered %0d accepted items and %0d results, frames 1x1 up to 128 wide",
             accepted, results);
    $display("idling phases: none, sender 58%%, receiver 58%%, both 28%%, long hold-off");
    if (expected_q.size() != 0)
      $display("%0d expected results never arrived", expected_q.size());
    if (errors == 0 && expected_q.size() == 0) $display("PASS conv3x3_image_filter");
    else $display("FAIL conv3x3_image_filter");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cfilt_pkg.sv
hdl/cfilt_if.sv
hdl/cfilt_linebuf.sv
hdl/cfilt_cell.sv
hdl/conv3x3_image_filter.sv
sim/testbench.sv
